// ===== rtl/mtfc_pkg.sv =====
// Shared constants and types for the motor telemetry frame checker.
// No dependencies; imported by every module of the block.
package mtfc_pkg;

    localparam int FRAME_LEN     = 16;
    localparam int CRC_LEN       = 14;
    localparam int PAYLOAD_FIRST = 2;
    localparam int PAYLOAD_LEN   = 12;
    localparam int MOTORS        = 4;

    localparam int CNT_W  = 5;
    localparam int SIDX_W = 4;

    localparam logic [15:0]      CRC_POLY   = 16'h1021;
    localparam logic [15:0]      CRC_TOP    = 16'h8000;
    localparam logic [CNT_W-1:0] IDLE_COUNT = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CRC_HI_IDX = CNT_W'(CRC_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] PAY_FIRST  = CNT_W'(PAYLOAD_FIRST);

    // 1 + 4*16 + 4*8 = 97 bits, padded to 13 bytes on the stream
    localparam int RESULT_W = 97;
    localparam int M_DATA_W = 104;

    typedef struct packed {
        logic [MOTORS-1:0][7:0]  currents;
        logic [MOTORS-1:0][15:0] positions;
        logic                    frame_ok;
    } result_t;

endpackage

// ===== rtl/mtfc_crc8.sv =====
// One-byte CRC-16 update, polynomial 0x1021, MSB first.
// Depends on mtfc_pkg for the polynomial constants.
module mtfc_crc8
    import mtfc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

// ===== rtl/mtfc_frame_core.sv =====
// Frame state: byte counter, running CRC, payload shadow and stored readings.
// Depends on mtfc_pkg and mtfc_crc8.
module mtfc_frame_core
    import mtfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    input  logic [7:0]    data_byte,
    input  logic          frame_start,
    output logic          has_result,
    output result_t       result
);

    logic [CNT_W-1:0]            cnt_reg, cnt_next, cnt_eff;
    logic [15:0]                 crc_reg, crc_next, crc_eff, crc_upd;
    logic [7:0]                  crc_hi_reg;
    logic [PAYLOAD_LEN-1:0][7:0] shadow_reg;
    logic [MOTORS-1:0][15:0]     pos_reg, pos_next;
    logic [MOTORS-1:0][7:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]            sidx_full;
    logic [SIDX_W-1:0]           sidx;
    logic                        active, in_crc, is_hi, is_last, frame_ok;

    mtfc_crc8 u_crc8
    (
        .crc_in  (crc_eff),
        .data    (data_byte),
        .crc_out (crc_upd)
    );

    assign cnt_eff   = frame_start ? '0 : cnt_reg;
    assign crc_eff   = frame_start ? 16'h0000 : crc_reg;
    assign active    = (cnt_eff < IDLE_COUNT);
    assign in_crc    = (cnt_eff < CRC_HI_IDX);
    assign is_hi     = (cnt_eff == CRC_HI_IDX);
    assign is_last   = (cnt_eff == LAST_IDX);
    assign sidx_full = cnt_eff - PAY_FIRST;
    assign sidx      = sidx_full[SIDX_W-1:0];
    assign frame_ok  = ({crc_hi_reg, data_byte} == crc_reg);

    // result only on the final byte; a start byte is always byte 0
    assign has_result = is_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        crc_next = crc_eff;
        pos_next = pos_reg;
        cur_next = cur_reg;
        if (active)
        begin
            if (in_crc)
            begin
                crc_next = crc_upd;
                cnt_next = cnt_eff + CNT_W'(1);
            end
            else if (is_hi)
            begin
                cnt_next = cnt_eff + CNT_W'(1);
            end
            else
            begin
                cnt_next = IDLE_COUNT;
                if (frame_ok)
                begin
                    for (int m = 0; m < MOTORS; m++)
                    begin
                        pos_next[m] = {shadow_reg[3*m], shadow_reg[3*m+1]};
                        cur_next[m] = shadow_reg[3*m+2];
                    end
                end
            end
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    assign result.frame_ok  = frame_ok;
    assign result.positions = pos_next;
    assign result.currents  = cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= IDLE_COUNT;
            crc_reg <= 16'h0000;
            pos_reg <= '0;
            cur_reg <= '0;
        end
        else if (enable)
        begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            cur_reg <= cur_next;
        end
    end

    // payload bytes and CRC high byte: no reset, always written before use
    always_ff @(posedge clk)
    begin
        if (enable && active && in_crc && (cnt_eff >= PAY_FIRST))
            shadow_reg[sidx] <= data_byte;
        if (enable && active && is_hi)
            crc_hi_reg <= data_byte;
    end

endmodule

// ===== rtl/mtfc_out_reg.sv =====
// Result register on the master stream side; holds a result while stalled.
// Depends on mtfc_pkg for the result type and stream width.
module mtfc_out_reg
    import mtfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             result,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                valid_reg;
    logic [RESULT_W-1:0] data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-RESULT_W){1'b0}}, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= result;
    end

endmodule

// ===== rtl/motor_telemetry_frame_checker.sv =====
// Motor telemetry frame checker: CRC-16 check of 16-byte frames, stored readings.
// Depends on mtfc_pkg, mtfc_frame_core and mtfc_out_reg.
//
// Usage:
//   Bytes enter on the slave stream, one per transfer; tuser marks byte 0 of
//   a frame. A start byte always opens a new frame and drops a partial one.
//   Bytes outside a frame are discarded. After byte 15 one result leaves on
//   the master stream: the match flag and the four stored position/current
//   readings, replaced by the frame's values only when the CRC matched.
//   The result is registered: byte 15 sits in the input register, and the
//   result register loads the result computed from it once it is free.
//   Throughput: one byte per cycle while no final byte waits for the result
//   register; the CRC byte update is one combinational step between the
//   input register and the state registers.
//   Reset clears the counter to idle, the CRC and all stored readings.
//   When the receiver stalls, the result is held; bytes that give no result
//   keep flowing, and the byte that ends the next frame waits in the input
//   register until the result register frees.
module motor_telemetry_frame_checker
    import mtfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] frame_start
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] frame_ok, [16:1] position_0,
                                           // [32:17] position_1, [48:33] position_2,
                                           // [64:49] position_3, [72:65] current_0,
                                           // [80:73] current_1, [88:81] current_2,
                                           // [96:89] current_3, [103:97] zero
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       has_result, out_free, advance;
    result_t    result;

    // retire the held byte unless its result cannot be stored
    assign advance  = in_valid_reg && (!has_result || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    mtfc_frame_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (advance),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .has_result  (has_result),
        .result      (result)
    );

    mtfc_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
